>>> rtl/sdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdm_pkg;

  localparam int NUM_DOTS_DEF = 26;
  localparam int DOT_W        = 6;
  localparam int IN_W         = 48;
  localparam int OUT_W        = 56;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 20;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_RATE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OFFSET   = 3'd4;

  localparam logic [15:0] ALPHA_RST   = 16'd13107;
  localparam logic [19:0] GAIN_RST    = 20'd100000;
  localparam logic [15:0] SPRING_RST  = 16'd400;
  localparam logic [15:0] DAMPING_RST = 16'd50;
  localparam logic [7:0]  MAXOFS_RST  = 8'd30;

  typedef logic signed [67:0] wide_t;

  // arithmetic shift right, rounding halves up
  function automatic wide_t rshr(input wide_t v, input int s);
    wide_t half;
    half = wide_t'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  // saturate to a signed field of the given width
  function automatic wide_t sat_to(input wide_t v, input int bits);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) return hi;
    else if (v < lo) return lo;
    else return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/spring_damper_dot_motion_unit.sv
// Spring-damper dot motion unit.
// Input stream (s_axis_*): one accelerometer sample per transaction, carrying
// accel_x, accel_y (already negated) and time_step. Output stream (m_axis_*):
// one transaction per dot, in dot order, with the dot's offset from rest;
// tlast marks the final dot of the sample.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wr_data);
// write it only while no sample is in flight.
// A sample is accepted and its gravity estimate is filtered per axis, then each
// dot is updated in turn, with a radial clamp only when its offset exceeds
// max_offset; the steps share the single 34x34 multiplier, and the clamp uses
// the one-bit-per-cycle square root and the one-bit-per-cycle divider per axis.
// s_axis_tready is high only between samples.
// The output register lets work on the next dot go on while a result waits;
// a stalled receiver holds the sequencer only when the next result is ready.
// Reset (synchronous, active high) restores the register defaults, clears
// the gravity estimate and marks every dot's position and velocity as zero.
`timescale 1ns / 1ps
`default_nettype none
module spring_damper_dot_motion_unit #(
  parameter int NUM_DOTS = sdm_pkg::NUM_DOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // accel_x [15:0], accel_y [31:16], time_step [47:32]
  input  logic [sdm_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // dot_index [5:0], offset_x [30:6], offset_y [55:31]
  output logic [sdm_pkg::OUT_W-1:0]      m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_wr_en,
  input  logic [sdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdm_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import sdm_pkg::*;

  localparam int IDX_W = (NUM_DOTS > 1) ? $clog2(NUM_DOTS) : 1;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_G0   = 5'd1;
  localparam logic [4:0] ST_G1   = 5'd2;
  localparam logic [4:0] ST_G2   = 5'd3;
  localparam logic [4:0] ST_G3   = 5'd4;
  localparam logic [4:0] ST_G4   = 5'd5;
  localparam logic [4:0] ST_D0   = 5'd6;
  localparam logic [4:0] ST_D1   = 5'd7;
  localparam logic [4:0] ST_D2   = 5'd8;
  localparam logic [4:0] ST_D3   = 5'd9;
  localparam logic [4:0] ST_D4   = 5'd10;
  localparam logic [4:0] ST_D5   = 5'd11;
  localparam logic [4:0] ST_D6   = 5'd12;
  localparam logic [4:0] ST_D7   = 5'd13;
  localparam logic [4:0] ST_Q0   = 5'd14;
  localparam logic [4:0] ST_Q1   = 5'd15;
  localparam logic [4:0] ST_Q2   = 5'd16;
  localparam logic [4:0] ST_SQ   = 5'd17;
  localparam logic [4:0] ST_DM   = 5'd18;
  localparam logic [4:0] ST_DW   = 5'd19;
  localparam logic [4:0] ST_DV   = 5'd20;
  localparam logic [4:0] ST_DF   = 5'd21;
  localparam logic [4:0] ST_EMIT = 5'd22;

  logic [15:0] filter_alpha;
  logic [19:0] lin_gain;
  logic [15:0] spring_rate;
  logic [15:0] damping_rate;
  logic [7:0]  max_offset;

  logic [4:0]       state;
  logic             axis;
  logic [DOT_W-1:0] dot;

  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic [15:0]        time_step;
  logic signed [31:0] gravity_x;
  logic signed [31:0] gravity_y;
  logic signed [33:0] lin;
  logic signed [43:0] gterm_x;
  logic signed [43:0] gterm_y;

  wide_t              acc;
  wide_t              mul_p;
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [47:0] force_q;
  logic signed [31:0] vel_new_x;
  logic signed [31:0] vel_new_y;
  logic signed [31:0] ofs_x;
  logic signed [31:0] ofs_y;

  logic [63:0] sq_v;
  logic [63:0] sq_res;
  logic [63:0] sq_bit;
  logic [24:0] num_lo;
  logic [33:0] rem;
  logic [24:0] quo;
  logic [4:0]  cnt;
  logic        dsign;

  logic signed [31:0] pos_x_mem [NUM_DOTS];
  logic signed [31:0] pos_y_mem [NUM_DOTS];
  logic signed [31:0] vel_x_mem [NUM_DOTS];
  logic signed [31:0] vel_y_mem [NUM_DOTS];
  logic [NUM_DOTS-1:0] vld;

  logic             out_valid;
  logic [OUT_W-1:0] out_data;
  logic             out_last;

  logic [IDX_W-1:0]   idx;
  logic signed [31:0] pos_rd;
  logic signed [31:0] vel_rd;
  logic signed [31:0] g_cur;
  logic signed [15:0] a_cur;
  logic signed [43:0] gt_cur;
  logic signed [31:0] vn_cur;
  logic signed [31:0] ofs_cur;
  logic [16:0]        one_minus_alpha;
  wide_t              grav_sum;
  logic signed [31:0] grav_new;
  wide_t              vel_sum;
  wide_t              pos_sum;
  logic [63:0]        d2;
  logic [63:0]        lim2;
  logic [63:0]        sq_try;
  logic [32:0]        root_div;
  logic [33:0]        rem_sh;
  logic [55:0]        num_full;
  logic [31:0]        quo_ext;
  logic               is_last;
  logic               emit_go;
  logic signed [33:0] ofs_abs;

  assign idx     = dot[IDX_W-1:0];
  assign pos_rd  = vld[idx] ? (axis ? pos_y_mem[idx] : pos_x_mem[idx]) : 32'sd0;
  assign vel_rd  = vld[idx] ? (axis ? vel_y_mem[idx] : vel_x_mem[idx]) : 32'sd0;
  assign g_cur   = axis ? gravity_y : gravity_x;
  assign a_cur   = axis ? accel_y : accel_x;
  assign gt_cur  = axis ? gterm_y : gterm_x;
  assign vn_cur  = axis ? vel_new_y : vel_new_x;
  assign ofs_cur = axis ? ofs_y : ofs_x;
  assign ofs_abs = ofs_cur[31] ? -34'(ofs_cur) : 34'(ofs_cur);

  assign one_minus_alpha = 17'h10000 - {1'b0, filter_alpha};
  assign grav_sum = acc + (mul_p <<< 16);
  assign grav_new = 32'(sat_to(rshr(grav_sum, 16), 32));
  assign vel_sum  = wide_t'(vel_rd) + rshr(acc + (mul_p <<< 24), 16);
  assign pos_sum  = wide_t'(pos_rd) + rshr(mul_p, 16);
  assign d2       = acc[63:0] + mul_p[63:0];
  assign lim2     = 64'(16'(max_offset) * 16'(max_offset)) << 32;
  assign sq_try   = sq_res + sq_bit;
  assign root_div = (sq_res[32:0] == 33'd0) ? 33'd1 : sq_res[32:0];
  assign rem_sh   = {rem[32:0], num_lo[cnt]};
  assign num_full = {mul_p[39:0], 16'd0};
  assign quo_ext  = 32'(quo);
  assign is_last  = (dot == DOT_W'(NUM_DOTS - 1));
  assign emit_go  = (state == ST_EMIT) && (!out_valid || m_axis_tready);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_G0: begin
        mul_a = 34'(g_cur);
        mul_b = {17'd0, one_minus_alpha};
      end
      ST_G1: begin
        mul_a = 34'(a_cur);
        mul_b = {18'd0, filter_alpha};
      end
      ST_G3: begin
        mul_a = lin;
        mul_b = {14'd0, lin_gain};
      end
      ST_D0: begin
        mul_a = 34'(pos_rd);
        mul_b = {18'd0, spring_rate};
      end
      ST_D1: begin
        mul_a = 34'(vel_rd);
        mul_b = {18'd0, damping_rate};
      end
      ST_D3: begin
        mul_a = {10'd0, force_q[23:0]};
        mul_b = {18'd0, time_step};
      end
      ST_D4: begin
        mul_a = 34'($signed(force_q[47:24]));
        mul_b = {18'd0, time_step};
      end
      ST_D6: begin
        mul_a = 34'(vn_cur);
        mul_b = {18'd0, time_step};
      end
      ST_Q0: begin
        mul_a = 34'(ofs_x);
        mul_b = 34'(ofs_x);
      end
      ST_Q1: begin
        mul_a = 34'(ofs_y);
        mul_b = 34'(ofs_y);
      end
      ST_DM: begin
        mul_a = ofs_abs;
        mul_b = {26'd0, max_offset};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_alpha <= ALPHA_RST;
      lin_gain     <= GAIN_RST;
      spring_rate  <= SPRING_RST;
      damping_rate <= DAMPING_RST;
      max_offset   <= MAXOFS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FILTER_ALPHA: filter_alpha <= cfg_wr_data[15:0];
        REG_LIN_GAIN:     lin_gain     <= cfg_wr_data;
        REG_SPRING_RATE:  spring_rate  <= cfg_wr_data[15:0];
        REG_DAMPING_RATE: damping_rate <= cfg_wr_data[15:0];
        REG_MAX_OFFSET:   max_offset   <= cfg_wr_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= 1'b0;
      dot       <= '0;
      gravity_x <= '0;
      gravity_y <= '0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            accel_x   <= $signed(s_axis_tdata[15:0]);
            accel_y   <= $signed(s_axis_tdata[31:16]);
            time_step <= s_axis_tdata[47:32];
            axis      <= 1'b0;
            state     <= ST_G0;
          end
        end
        ST_G0: state <= ST_G1;
        ST_G1: begin
          acc   <= mul_p;
          state <= ST_G2;
        end
        ST_G2: begin
          if (axis) gravity_y <= grav_new;
          else gravity_x <= grav_new;
          lin   <= (34'(a_cur) <<< 16) - 34'(grav_new);
          state <= ST_G3;
        end
        ST_G3: state <= ST_G4;
        ST_G4: begin
          if (axis) begin
            gterm_y <= 44'(rshr(-mul_p, 12));
            axis    <= 1'b0;
            dot     <= '0;
            state   <= ST_D0;
          end else begin
            gterm_x <= 44'(rshr(-mul_p, 12));
            axis    <= 1'b1;
            state   <= ST_G0;
          end
        end
        ST_D0: state <= ST_D1;
        ST_D1: begin
          acc   <= wide_t'(gt_cur) - mul_p;
          state <= ST_D2;
        end
        ST_D2: begin
          force_q <= 48'(sat_to(acc - mul_p, 48));
          state   <= ST_D3;
        end
        ST_D3: state <= ST_D4;
        ST_D4: begin
          acc   <= mul_p;
          state <= ST_D5;
        end
        ST_D5: begin
          if (axis) vel_new_y <= 32'(sat_to(vel_sum, 32));
          else vel_new_x <= 32'(sat_to(vel_sum, 32));
          state <= ST_D6;
        end
        ST_D6: state <= ST_D7;
        ST_D7: begin
          if (axis) begin
            ofs_y <= 32'(sat_to(pos_sum, 32));
            axis  <= 1'b0;
            state <= ST_Q0;
          end else begin
            ofs_x <= 32'(sat_to(pos_sum, 32));
            axis  <= 1'b1;
            state <= ST_D0;
          end
        end
        ST_Q0: state <= ST_Q1;
        ST_Q1: begin
          acc   <= mul_p;
          state <= ST_Q2;
        end
        ST_Q2: begin
          sq_v   <= d2;
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
          if (d2 > lim2) state <= ST_SQ;
          else state <= ST_EMIT;
        end
        ST_SQ: begin
          if (sq_v >= sq_try) begin
            sq_v   <= sq_v - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            axis  <= 1'b0;
            state <= ST_DM;
          end
        end
        ST_DM: begin
          dsign <= ofs_cur[31];
          state <= ST_DW;
        end
        ST_DW: begin
          num_lo <= num_full[24:0];
          rem    <= 34'(num_full[55:25]);
          quo    <= '0;
          cnt    <= 5'd24;
          state  <= ST_DV;
        end
        ST_DV: begin
          if (rem_sh >= 34'(root_div)) begin
            rem <= rem_sh - 34'(root_div);
            quo <= {quo[23:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[23:0], 1'b0};
          end
          if (cnt == 5'd0) state <= ST_DF;
          else cnt <= cnt - 5'd1;
        end
        ST_DF: begin
          if (axis) begin
            ofs_y <= dsign ? -quo_ext : quo_ext;
            axis  <= 1'b0;
            state <= ST_EMIT;
          end else begin
            ofs_x <= dsign ? -quo_ext : quo_ext;
            axis  <= 1'b1;
            state <= ST_DM;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            vld[idx] <= 1'b1;
            if (is_last) state <= ST_IDLE;
            else begin
              dot   <= dot + DOT_W'(1);
              state <= ST_D0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // per-dot state and output register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      pos_x_mem[idx] <= ofs_x;
      pos_y_mem[idx] <= ofs_y;
      vel_x_mem[idx] <= vel_new_x;
      vel_y_mem[idx] <= vel_new_y;
      out_data       <= {ofs_y[24:0], ofs_x[24:0], dot};
      out_last       <= is_last;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

endmodule
`default_nettype wire

>>> rtl/sdm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sdm_checker #(
  parameter int NUM_DOTS = sdm_pkg::NUM_DOTS_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [sdm_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);
  import sdm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  a_rst_clear: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a sample in flight blocks the next one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[DOT_W-1:0] == DOT_W'(NUM_DOTS - 1))
    else $error("tlast on a dot other than the final one");

  a_not_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[DOT_W-1:0] != DOT_W'(NUM_DOTS - 1))
    else $error("final dot without tlast");

endmodule

bind spring_damper_dot_motion_unit sdm_checker #(.NUM_DOTS(NUM_DOTS)) u_sdm_checker (.*);
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sdm_pkg::*;

  localparam int NDOTS = NUM_DOTS_DEF;

  typedef struct packed {
    logic [5:0]         dot;
    logic signed [24:0] ofs_x;
    logic signed [24:0] ofs_y;
    logic               last;
  } dot_offset_t;

  // Fixed-point predictor of the dot motion, plus the queue of offsets it expects.
  class dot_motion_board;
    longint alpha, gain, spring, damping, max_ofs;
    longint grav_x, grav_y;
    longint px[NDOTS], py[NDOTS], vx[NDOTS], vy[NDOTS];
    dot_offset_t pending[$];
    int errors;

    function void clear_state();
      alpha = ALPHA_RST; gain = GAIN_RST; spring = SPRING_RST;
      damping = DAMPING_RST; max_ofs = MAXOFS_RST;
      grav_x = 0; grav_y = 0;
      for (int i = 0; i < NDOTS; i++) begin
        px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FILTER_ALPHA: alpha = val[15:0];
        REG_LIN_GAIN:     gain = val;
        REG_SPRING_RATE:  spring = val[15:0];
        REG_DAMPING_RATE: damping = val[15:0];
        REG_MAX_OFFSET:   max_ofs = val[7:0];
        default: ;
      endcase
    endfunction

    // 64-bit arithmetic right shift is a floor shift
    function longint rnd_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function longint low_pass(longint g, longint a);
      return clip(rnd_shift(g * (65536 - alpha) + (a * 65536) * alpha, 16), 32);
    endfunction

    function longint next_vel(longint v, longint p, longint lin, longint dt);
      longint f;
      f = rnd_shift(-(lin * gain), 12) - p * spring - v * damping;
      f = clip(f, 48);
      return clip(v + rnd_shift(f * dt, 16), 32);
    endfunction

    function void note_sample(logic [IN_W-1:0] d);
      longint ax, ay, dt, lx, ly, lim, dx, dy;
      longint unsigned d2, lim2, root_v;
      dot_offset_t r;
      ax = longint'($signed(d[15:0]));
      ay = longint'($signed(d[31:16]));
      dt = longint'(d[47:32]);
      lim = max_ofs << 16;
      lim2 = lim * lim;
      grav_x = low_pass(grav_x, ax);
      grav_y = low_pass(grav_y, ay);
      lx = ax * 65536 - grav_x;
      ly = ay * 65536 - grav_y;
      for (int i = 0; i < NDOTS; i++) begin
        vx[i] = next_vel(vx[i], px[i], lx, dt);
        vy[i] = next_vel(vy[i], py[i], ly, dt);
        dx = clip(px[i] + rnd_shift(vx[i] * dt, 16), 32);
        dy = clip(py[i] + rnd_shift(vy[i] * dt, 16), 32);
        d2 = longint'(dx * dx) + longint'(dy * dy);
        if (d2 > lim2) begin
          root_v = root(d2);
          if (root_v < 1) root_v = 1;
          dx = (dx * lim) / longint'(root_v);
          dy = (dy * lim) / longint'(root_v);
        end
        px[i] = dx; py[i] = dy;
        r.dot = 6'(i);
        r.ofs_x = dx[24:0];
        r.ofs_y = dy[24:0];
        r.last = (i == NDOTS - 1);
        pending.push_back(r);
      end
    endfunction

    function void check_dot(logic [OUT_W-1:0] d, logic last);
      dot_offset_t e;
      if (pending.size() == 0) begin
        $error("unexpected dot offset %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[5:0] !== e.dot) begin
        $error("dot_index exp %0d got %0d", e.dot, d[5:0]); errors++;
      end
      if (d[30:6] !== e.ofs_x) begin
        $error("offset_x exp %0d got %0d", e.ofs_x, $signed(d[30:6])); errors++;
      end
      if (d[55:31] !== e.ofs_y) begin
        $error("offset_y exp %0d got %0d", e.ofs_y, $signed(d[55:31])); errors++;
      end
      if (last !== e.last) begin
        $error("last_dot exp %0d got %0d", e.last, last); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
  logic [IN_W-1:0] s_tdata;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  int send_idle_pct, recv_stall_pct;
  bit hold_recv;
  dot_motion_board board;

  spring_damper_dot_motion_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .m_axis_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls, or held off entirely
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) board.check_dot(m_tdata, m_tlast);
      m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // tvalid stays high after a transaction until the next idle cycle or drain
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= {dt, ay, ax};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_sample(s_tdata);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_wr_data <= val;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic set_all(int a, int g, int s, int d, int m);
    write_reg(REG_FILTER_ALPHA, CFG_DATA_W'(a));
    write_reg(REG_LIN_GAIN, CFG_DATA_W'(g));
    write_reg(REG_SPRING_RATE, CFG_DATA_W'(s));
    write_reg(REG_DAMPING_RATE, CFG_DATA_W'(d));
    write_reg(REG_MAX_OFFSET, CFG_DATA_W'(m));
    cfg_wr_en <= 1'b0;
  endtask

  // mostly small motions with occasional full-scale ones
  task automatic random_samples(int n);
    logic [15:0] ax, ay, dt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        ax = 16'($urandom); ay = 16'($urandom); dt = 16'($urandom);
      end else begin
        ax = 16'($urandom_range(8191) - 4096);
        ay = 16'($urandom_range(8191) - 4096);
        dt = 16'($urandom_range(2000));
      end
      send_sample(ax, ay, dt);
    end
  endtask

  initial begin
    board = new();
    board.clear_state();
    rst = 1; s_tvalid = 0; s_tdata = '0; hold_recv = 0;
    cfg_wr_en = 0; cfg_index = '0; cfg_wr_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, zero step, clamp and no clamp
    send_sample(16'sd0, 16'sd0, 16'd0);
    send_sample(16'sh7fff, 16'sh8000, 16'd1092);
    send_sample(16'sh8000, 16'sh7fff, 16'hffff);
    send_sample(16'sd4096, -16'sd4096, 16'd0);
    send_sample(16'sh7fff, 16'sh7fff, 16'hffff);
    send_sample(16'sh8000, 16'sh8000, 16'd1);
    send_sample(16'sd100, -16'sd100, 16'd500);
    drain();
    set_all(65535, 1048575, 65535, 65535, 255);
    send_sample(16'sh7fff, 16'sh8000, 16'hffff);
    send_sample(16'sh8000, 16'sh7fff, 16'hffff);
    send_sample(16'sd1, 16'sd1, 16'd100);
    drain();
    set_all(0, 0, 0, 0, 1);
    send_sample(16'sh7fff, 16'sh8000, 16'hffff);
    send_sample(16'sd0, 16'sd0, 16'd1000);
    drain();
    set_all(13107, 100000, 400, 50, 30);

    // phases of idling
    random_samples(90);
    send_idle_pct = 84;
    random_samples(60);
    send_idle_pct = 0; recv_stall_pct = 84;
    random_samples(60);
    send_idle_pct = 30; recv_stall_pct = 30;
    random_samples(60);
    drain();

    // long receiver hold-off while samples keep coming
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        hold_recv = 1;
        repeat (3000) @(posedge clk);
        hold_recv = 0;
      end
      random_samples(8);
    join
    drain();

    set_all($urandom_range(65535), $urandom_range(1048575), $urandom_range(65535),
            $urandom_range(65535), $urandom_range(255, 1));
    random_samples(80);
    drain();
    set_all(65535, 0, 1, 0, 1);
    recv_stall_pct = 30;
    random_samples(40);
    drain();
    set_all(1, 1048575, 0, 65535, 128);
    send_idle_pct = 30;
    random_samples(50);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
